// File: sv/recf_pkg.sv
// ----------------------------------------------------------------------------
// recf_pkg
// Shared widths, state and event codes, register indexes and reset values
// for the rotary encoder click decoder.
// ----------------------------------------------------------------------------
package recf_pkg;

    localparam int THR_W   = 16;
    localparam int STATE_W = 4;
    localparam int EV_W    = 3;
    localparam int IDX_W   = 1;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 8;

    // decoder states
    localparam logic [STATE_W-1:0] ST_IDLE        = 4'd0;
    localparam logic [STATE_W-1:0] ST_START_RIGHT = 4'd1;
    localparam logic [STATE_W-1:0] ST_START_LEFT  = 4'd2;
    localparam logic [STATE_W-1:0] ST_ROT_RIGHT   = 4'd3;
    localparam logic [STATE_W-1:0] ST_ROT_LEFT    = 4'd4;
    localparam logic [STATE_W-1:0] ST_HELD        = 4'd5;
    localparam logic [STATE_W-1:0] ST_SIMPLE      = 4'd6;
    localparam logic [STATE_W-1:0] ST_LONG        = 4'd7;
    localparam logic [STATE_W-1:0] ST_VERY_LONG   = 4'd8;

    // events, one per tick
    localparam logic [EV_W-1:0] EV_NONE        = 3'd0;
    localparam logic [EV_W-1:0] EV_FALL_LEFT   = 3'd1;
    localparam logic [EV_W-1:0] EV_RISE_LEFT   = 3'd2;
    localparam logic [EV_W-1:0] EV_FALL_RIGHT  = 3'd3;
    localparam logic [EV_W-1:0] EV_RISE_RIGHT  = 3'd4;
    localparam logic [EV_W-1:0] EV_FALL_BUTTON = 3'd5;
    localparam logic [EV_W-1:0] EV_RISE_BUTTON = 3'd6;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_LONG_THR  = 1'b0;
    localparam logic [IDX_W-1:0] REG_VLONG_THR = 1'b1;

    localparam logic [THR_W-1:0] LONG_THR_RST  = 16'd30;
    localparam logic [THR_W-1:0] VLONG_THR_RST = 16'd90;

    function automatic logic is_gesture(input logic [STATE_W-1:0] st);
        return (st == ST_ROT_RIGHT) || (st == ST_ROT_LEFT) || (st == ST_SIMPLE) ||
               (st == ST_LONG) || (st == ST_VERY_LONG);
    endfunction

endpackage

// File: sv/rotary_encoder_click_fsm_top.sv
// ----------------------------------------------------------------------------
// rotary_encoder_click_fsm_top
// Quadrature and push-button click decoder for an active-low rotary encoder.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request per sampling tick carrying the A, B and button
//   pin levels. m_ channel: one request per accepted sample carrying the
//   decoder state after that sample and a flag marking a reported gesture
//   (rotation right/left, simple, long or very long click).
//   cfg_ port: writes the long and very long hold thresholds; taken in the
//   cycle cfg_we is high, no read-back.
// Timing and throughput: a result appears in the cycle after its sample is
//   accepted. One sample is accepted every cycle unless stalled; the single
//   output register decouples the sides, so s_tready stays high while the
//   held result is taken in the same cycle.
// Reset (aresetn low, synchronous): previous levels go high, state to idle,
//   hold counter to zero, thresholds to 30 and 90, output register empty.
// Stall: while m_tready is low and a result is held, s_tready drops and the
//   decoder state does not advance; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module rotary_encoder_click_fsm_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: [0] level_a, [1] level_b, [2] level_button, rest zero
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [recf_pkg::S_DATA_W-1:0] s_tdata,
    // m_tdata: [3:0] fsm_state, [4] gesture_done, rest zero
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [recf_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          cfg_we,
    input  logic [recf_pkg::IDX_W-1:0]    cfg_index,
    input  logic [recf_pkg::THR_W-1:0]    cfg_wdata
);
    import recf_pkg::*;

    logic [THR_W-1:0]   long_thr_reg, vlong_thr_reg;
    logic [2:0]         prev_reg;
    logic [STATE_W-1:0] state_reg, state_next;
    logic [THR_W-1:0]   hold_reg, hold_next, hold_inc;
    logic               m_valid_reg;
    logic [STATE_W-1:0] out_state_reg;
    logic               out_done_reg;

    logic               accept;
    logic               lvl_a, lvl_b, lvl_btn;
    logic [EV_W-1:0]    ev;

    assign lvl_a   = s_tdata[0];
    assign lvl_b   = s_tdata[1];
    assign lvl_btn = s_tdata[2];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // priority: right over left over button
    always_comb begin
        if (lvl_b != prev_reg[1]) begin
            ev = lvl_b ? EV_RISE_RIGHT : EV_FALL_RIGHT;
        end else if (lvl_a != prev_reg[0]) begin
            ev = lvl_a ? EV_RISE_LEFT : EV_FALL_LEFT;
        end else if (lvl_btn != prev_reg[2]) begin
            ev = lvl_btn ? EV_RISE_BUTTON : EV_FALL_BUTTON;
        end else begin
            ev = EV_NONE;
        end
    end

    assign hold_inc = (hold_reg == {THR_W{1'b1}}) ? hold_reg : hold_reg + 1'b1;

    always_comb begin
        state_next = state_reg;
        hold_next  = hold_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (ev == EV_FALL_RIGHT) begin
                    state_next = ST_START_RIGHT;
                end else if (ev == EV_FALL_LEFT) begin
                    state_next = ST_START_LEFT;
                end else if (ev == EV_FALL_BUTTON) begin
                    state_next = ST_HELD;
                end
            end
            ST_START_RIGHT: begin
                if (ev == EV_FALL_LEFT) begin
                    state_next = ST_ROT_RIGHT;
                end else if (ev == EV_RISE_RIGHT) begin
                    state_next = ST_IDLE;
                end
            end
            ST_START_LEFT: begin
                if (ev == EV_FALL_RIGHT) begin
                    state_next = ST_ROT_LEFT;
                end else if (ev == EV_RISE_LEFT) begin
                    state_next = ST_IDLE;
                end
            end
            ST_HELD: begin
                // count includes this tick before the threshold compare
                hold_next = hold_inc;
                if (ev == EV_RISE_BUTTON) begin
                    if (hold_inc > vlong_thr_reg) begin
                        state_next = ST_VERY_LONG;
                    end else if (hold_inc > long_thr_reg) begin
                        state_next = ST_LONG;
                    end else begin
                        state_next = ST_SIMPLE;
                    end
                    hold_next = '0;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_thr_reg  <= LONG_THR_RST;
            vlong_thr_reg <= VLONG_THR_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_LONG_THR:  long_thr_reg  <= cfg_wdata;
                REG_VLONG_THR: vlong_thr_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg    <= 3'b111;
            state_reg   <= ST_IDLE;
            hold_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                prev_reg  <= {lvl_btn, lvl_b, lvl_a};
                state_reg <= state_next;
                hold_reg  <= hold_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_state_reg <= state_next;
            out_done_reg  <= is_gesture(state_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-STATE_W-1){1'b0}}, out_done_reg, out_state_reg};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_hold_only_when_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (hold_reg != '0) |-> (state_reg == ST_HELD))
        else $error("hold counter running outside held state");

    a_gesture_one_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_gesture(state_reg)) |=> (state_reg == ST_IDLE))
        else $error("reported gesture did not return to idle");

    a_out_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_state_reg == state_reg))
        else $error("held result differs from decoder state");

    a_done_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_done_reg == is_gesture(out_state_reg)))
        else $error("gesture flag inconsistent with state code");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_tready && !s_tvalid) |=> !m_valid_reg)
        else $error("result repeated after being taken");

endmodule

// File: sim/rotary_encoder_click_fsm_top_tb.sv
// ----------------------------------------------------------------------------
// rotary_encoder_click_fsm_top_tb
// Self-checking bench for the rotary encoder quadrature and click decoder.
// A short table of pin-level requests covers rotations, false starts, clicks
// and masked edges. Random quadrature, button and noise sequences follow
// under several threshold settings. Every result is compared with the
// table's fixed state where one is given, else with a local decoder model.
// ----------------------------------------------------------------------------
module rotary_encoder_click_fsm_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import recf_pkg::*;

    typedef struct packed {
        logic [STATE_W-1:0] st;
        logic               done;
    } result_t;

    typedef struct packed {
        logic [2:0]         lv;     // {button, b, a}
        bit                 fixed;
        logic [STATE_W-1:0] st;
    } step_row_t;

    localparam int N_DIRECTED = 27;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_we    = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [THR_W-1:0]    cfg_wdata = '0;

    // local copy of the decoder
    logic [THR_W-1:0]   long_thr  = LONG_THR_RST;
    logic [THR_W-1:0]   vlong_thr = VLONG_THR_RST;
    logic [2:0]         prev_lv   = 3'b111;
    logic [STATE_W-1:0] dec_state = ST_IDLE;
    logic [THR_W-1:0]   hold_cnt  = '0;

    result_t pending[$];
    result_t want;
    int      fail_count = 0;
    int      n_sent     = 0;
    bit      quiet      = 1'b0;

    step_row_t directed_rows [N_DIRECTED] = '{
        '{3'b111, 1'b1, ST_IDLE},        // no edge straight after reset
        '{3'b101, 1'b1, ST_START_RIGHT},
        '{3'b100, 1'b1, ST_ROT_RIGHT},
        '{3'b100, 1'b1, ST_IDLE},
        '{3'b110, 1'b1, ST_IDLE},
        '{3'b111, 1'b1, ST_IDLE},
        '{3'b110, 1'b1, ST_START_LEFT},
        '{3'b100, 1'b1, ST_ROT_LEFT},
        '{3'b101, 1'b1, ST_IDLE},
        '{3'b100, 1'b1, ST_START_LEFT},  // left start with B already low
        '{3'b110, 1'b1, ST_START_LEFT},  // B rising must not drop a left start
        '{3'b111, 1'b1, ST_IDLE},
        '{3'b101, 1'b1, ST_START_RIGHT},
        '{3'b111, 1'b1, ST_IDLE},
        '{3'b110, 1'b1, ST_START_LEFT},
        '{3'b111, 1'b1, ST_IDLE},
        '{3'b011, 1'b1, ST_HELD},
        '{3'b011, 1'b1, ST_HELD},
        '{3'b111, 1'b1, ST_SIMPLE},
        '{3'b011, 1'b1, ST_IDLE},        // press during a gesture is ignored
        '{3'b111, 1'b1, ST_IDLE},
        '{3'b011, 1'b1, ST_HELD},
        '{3'b001, 1'b1, ST_HELD},
        '{3'b100, 1'b1, ST_HELD},        // release masked by the A edge
        '{3'b111, 1'b1, ST_HELD},
        '{3'b011, 1'b1, ST_HELD},
        '{3'b111, 1'b0, ST_IDLE}
    };

    rotary_encoder_click_fsm_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // one tick of the decoder: edge priority right, left, button
    function automatic logic [STATE_W-1:0] decode_sample(input logic [2:0] lv);
        logic [EV_W-1:0]    ev;
        logic [STATE_W-1:0] nxt;
        ev = EV_NONE;
        if (lv[1] != prev_lv[1])
            ev = lv[1] ? EV_RISE_RIGHT : EV_FALL_RIGHT;
        else if (lv[0] != prev_lv[0])
            ev = lv[0] ? EV_RISE_LEFT : EV_FALL_LEFT;
        else if (lv[2] != prev_lv[2])
            ev = lv[2] ? EV_RISE_BUTTON : EV_FALL_BUTTON;
        prev_lv = lv;
        nxt = dec_state;
        case (dec_state)
            ST_IDLE: begin
                if (ev == EV_FALL_RIGHT)
                    nxt = ST_START_RIGHT;
                else if (ev == EV_FALL_LEFT)
                    nxt = ST_START_LEFT;
                else if (ev == EV_FALL_BUTTON)
                    nxt = ST_HELD;
            end
            ST_START_RIGHT: begin
                if (ev == EV_FALL_LEFT)
                    nxt = ST_ROT_RIGHT;
                else if (ev == EV_RISE_RIGHT)
                    nxt = ST_IDLE;
            end
            ST_START_LEFT: begin
                if (ev == EV_FALL_RIGHT)
                    nxt = ST_ROT_LEFT;
                else if (ev == EV_RISE_LEFT)
                    nxt = ST_IDLE;
            end
            ST_HELD: begin
                if (hold_cnt != '1)
                    hold_cnt = hold_cnt + 1'b1;
                if (ev == EV_RISE_BUTTON) begin
                    if (hold_cnt > vlong_thr)
                        nxt = ST_VERY_LONG;
                    else if (hold_cnt > long_thr)
                        nxt = ST_LONG;
                    else
                        nxt = ST_SIMPLE;
                    hold_cnt = '0;
                end
            end
            default: begin
                nxt = ST_IDLE;
            end
        endcase
        dec_state = nxt;
        return nxt;
    endfunction

    task automatic report_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t ns: %s", $time, what);
    endtask

    // drive one request; state is taken from the model unless fixed is set
    task automatic send_sample(input logic [2:0] lv, input bit fixed,
                               input logic [STATE_W-1:0] fixed_st);
        logic [STATE_W-1:0] st;
        while (!quiet && $urandom_range(0, 99) < 18) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-3){1'b0}}, lv};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        st = decode_sample(lv);
        if (fixed)
            st = fixed_st;
        pending.push_back('{st: st, done: (st inside {ST_ROT_RIGHT, ST_ROT_LEFT,
                                                      ST_SIMPLE, ST_LONG,
                                                      ST_VERY_LONG})});
        n_sent++;
    endtask

    task automatic tick(input logic [2:0] lv, input int n);
        repeat (n) send_sample(lv, 1'b0, ST_IDLE);
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [THR_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_LONG_THR)
            long_thr = val;
        else
            vlong_thr = val;
    endtask

    task automatic set_thresholds(input logic [THR_W-1:0] lt, input logic [THR_W-1:0] vt);
        drain();
        write_reg(REG_LONG_THR, lt);
        write_reg(REG_VLONG_THR, vt);
    endtask

    // hold length aimed at the thresholds where they are reachable
    function automatic int pick_hold();
        int h;
        case ($urandom_range(0, 3))
            0: h = $urandom_range(1, 4);
            1: h = (long_thr < 200) ? long_thr + $urandom_range(0, 2) : $urandom_range(1, 40);
            2: h = (vlong_thr < 200) ? vlong_thr + $urandom_range(0, 2) : $urandom_range(1, 60);
            default: h = $urandom_range(1, 60);
        endcase
        return (h < 1) ? 1 : h;
    endfunction

    // walk the decoder back to idle with all pins released
    task automatic return_to_idle();
        while (dec_state != ST_IDLE) begin
            if (dec_state == ST_HELD)
                tick(prev_lv ^ 3'b100, 1);
            else if (dec_state == ST_START_LEFT)
                tick(prev_lv ^ 3'b010, 1);
            else
                tick(3'b111, 1);
        end
        tick(3'b111, 1);
    endtask

    task automatic run_random(input int count);
        int target;
        int r;
        int n;
        target = n_sent + count;
        while (n_sent < target) begin
            r = $urandom_range(0, 99);
            n = $urandom_range(1, 3);
            if (r < 22) begin
                tick(3'b101, n); tick(3'b100, n); tick(3'b110, n); tick(3'b111, n);
            end else if (r < 44) begin
                tick(3'b110, n); tick(3'b100, n); tick(3'b101, n); tick(3'b111, n);
            end else if (r < 54) begin
                if ($urandom_range(0, 1)) begin
                    tick(3'b101, n); tick(3'b111, n);
                end else begin
                    tick(3'b110, n); tick(3'b111, n);
                end
            end else if (r < 80) begin
                tick(3'b011, pick_hold());
                tick(3'b111, n);
            end else begin
                repeat ($urandom_range(1, 6)) tick(3'($urandom_range(0, 7)), 1);
            end
        end
    endtask

    always @(negedge aclk) begin
        m_tready <= quiet || ($urandom_range(0, 99) >= 18);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending.size() == 0) begin
                report_failure($sformatf("unexpected result 0x%02h", m_tdata));
            end else begin
                want = pending.pop_front();
                if (m_tdata[3:0] !== want.st || m_tdata[4] !== want.done)
                    report_failure($sformatf(
                        "fsm_state exp %0d got %0d, gesture_done exp %0b got %0b",
                        want.st, m_tdata[3:0], want.done, m_tdata[4]));
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_sample(directed_rows[i].lv, directed_rows[i].fixed, directed_rows[i].st);
        run_random(200);

        set_thresholds('0, '0);
        run_random(200);

        // both at maximum: every release is a simple click; no back-pressure here
        set_thresholds('1, '1);
        quiet = 1'b1;
        run_random(200);
        quiet = 1'b0;

        set_thresholds(16'd20, 16'd5);
        run_random(200);

        set_thresholds(16'hFFFE, 16'hFFFF);
        return_to_idle();
        run_random(200);

        set_thresholds(THR_W'($urandom_range(0, 40)), THR_W'($urandom_range(0, 100)));
        run_random(200);

        drain();
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
